// File: hw/rtl/ire_pkg.sv
// Shared types and constants for the interpolation residual encoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ire_pkg;

   // Fixed result field widths
   localparam int INDEX_W        = 12;
   localparam int VALUE_W        = 16;

   // Block size register
   localparam int CFG_W          = 4;
   localparam logic [CFG_W-1:0] CFG_RESET = 4'd9;
   localparam int MIN_BLOCK_LOG2 = 2;

   // Job queue between predictor and output serializer
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_W         = 2;
   localparam int QCNT_W         = 3;

   // Up to four results per job
   localparam int BEAT_W         = 2;

   // Result channel packing
   localparam int RSP_TDATA_W    = 32;
   localparam int RSP_TUSER_W    = 2;
   localparam int RSP_PAD_W      = RSP_TDATA_W - INDEX_W - VALUE_W;

   typedef enum logic {
      KIND_FULL     = 1'b0,
      KIND_RESIDUAL = 1'b1
   } kind_type;

   // Per-anchor job descriptor
   typedef struct packed {
      logic               only_full;  // block start: no pending residuals
      logic               is_last;    // final sample of the block
      logic [INDEX_W-1:0] full_idx;
      logic [INDEX_W-1:0] res_base;   // residual index of first held sample
   } job_ctrl_type;

   localparam int JOB_CTRL_W = $bits(job_ctrl_type);

endpackage

`default_nettype wire

// File: hw/rtl/ire_front.sv
// Front end: sample acceptance, block position tracking, anchor detection
// and interpolation numerators. Depends on ire_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ire_front
   import ire_pkg::*;
#(
   parameter int MAX_BLOCK_LOG2 = 12,
   parameter int SAMPLE_WIDTH   = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wen,
   input  logic [CFG_W-1:0]                       csr_wdata,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      req_tdata,
   input  logic                                   credit_ok,
   output logic                                   j1_valid,
   output job_ctrl_type                           j1_ctrl,
   output logic signed [SAMPLE_WIDTH+1:0]         j1_n1,
   output logic signed [SAMPLE_WIDTH+1:0]         j1_n2,
   output logic signed [SAMPLE_WIDTH+1:0]         j1_n3,
   output logic signed [SAMPLE_WIDTH-1:0]         j1_s,
   output logic signed [SAMPLE_WIDTH-1:0]         j1_h0,
   output logic signed [SAMPLE_WIDTH-1:0]         j1_h1,
   output logic signed [SAMPLE_WIDTH-1:0]         j1_h2
);

   localparam int PW = MAX_BLOCK_LOG2;
   localparam int SW = SAMPLE_WIDTH;
   localparam int NW = SAMPLE_WIDTH + 2;
   localparam int KW = CFG_W + 1;

   logic [CFG_W-1:0]     bsl_ff, bsl_in;
   logic [PW-1:0]        pos_ff, pos_in;
   logic signed [SW-1:0] anchor_ff;
   logic signed [SW-1:0] held_ff [3];
   logic                 v1_ff, v1_in;

   job_ctrl_type         ctrl_ff;
   logic signed [NW-1:0] n1_ff, n2_ff, n3_ff;
   logic signed [SW-1:0] s_ff, h0_ff, h1_ff, h2_ff;

   logic [KW-1:0]        k_eff;
   logic [PW-1:0]        size_mask;
   logic [PW-1:0]        p;
   logic [PW-1:0]        grp;
   logic [PW-1:0]        g;
   logic [PW-1:0]        g3;
   logic [PW-1:0]        fidx;
   logic                 is_last;
   logic                 quarter;
   logic                 anchor;
   logic                 accept;
   logic signed [SW-1:0] smp;
   logic signed [NW-1:0] a_x, s_x;
   logic signed [NW-1:0] n1, n2, n3;
   job_ctrl_type         ctrl;

   // Clamp block size to the supported range, then build the position mask
   always_comb begin
      priority if ({1'b0, bsl_ff} < KW'(MIN_BLOCK_LOG2)) begin
         k_eff = KW'(MIN_BLOCK_LOG2);
      end else if ({1'b0, bsl_ff} > KW'(MAX_BLOCK_LOG2)) begin
         k_eff = KW'(MAX_BLOCK_LOG2);
      end else begin
         k_eff = {1'b0, bsl_ff};
      end
   end

   always_comb begin
      for (int i = 0; i < PW; i++) begin
         size_mask[i] = (KW'(i) < k_eff);
      end
   end

   assign p       = pos_ff & size_mask;
   assign is_last = (p == size_mask);
   assign quarter = (p[1:0] == 2'b00);
   assign anchor  = is_last || quarter;

   // Held samples need no room downstream
   assign req_tready = !anchor || credit_ok;
   assign accept     = req_tvalid && req_tready;

   assign smp = req_tdata[SW-1:0];
   assign a_x = NW'(anchor_ff);
   assign s_x = NW'(smp);

   // Thirds for the final group, quarters elsewhere
   always_comb begin
      if (is_last) begin
         n1 = (a_x <<< 1) + s_x;
         n2 = a_x + (s_x <<< 1);
      end else begin
         n1 = (a_x <<< 1) + a_x + s_x;
         n2 = a_x + s_x;
      end
      n3 = a_x + (s_x <<< 1) + s_x;
   end

   assign grp  = p >> 2;
   assign g    = is_last ? grp : grp - PW'(1);
   assign g3   = (g << 1) + g;
   assign fidx = is_last ? grp + PW'(1) : grp;

   always_comb begin
      ctrl.only_full = (p == '0);
      ctrl.is_last   = is_last;
      ctrl.full_idx  = INDEX_W'(fidx);
      ctrl.res_base  = INDEX_W'(g3);
   end

   always_comb begin
      bsl_in = bsl_ff;
      pos_in = pos_ff;
      if (csr_wen) begin
         bsl_in = csr_wdata;
         pos_in = '0;
      end else if (accept) begin
         pos_in = (p + PW'(1)) & size_mask;
      end
   end

   assign v1_in = accept && anchor;

   always_ff @(posedge clock) begin
      if (reset) begin
         bsl_ff    <= CFG_RESET;
         pos_ff    <= '0;
         anchor_ff <= '0;
         v1_ff     <= 1'b0;
      end else begin
         bsl_ff <= bsl_in;
         pos_ff <= pos_in;
         v1_ff  <= v1_in;
         if (accept && anchor) begin
            anchor_ff <= smp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !anchor) begin
         unique case (p[1:0])
            2'b01:   held_ff[0] <= smp;
            2'b10:   held_ff[1] <= smp;
            2'b11:   held_ff[2] <= smp;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (v1_in) begin
         ctrl_ff <= ctrl;
         n1_ff   <= n1;
         n2_ff   <= n2;
         n3_ff   <= n3;
         s_ff    <= smp;
         h0_ff   <= held_ff[0];
         h1_ff   <= held_ff[1];
         h2_ff   <= held_ff[2];
      end
   end

   assign j1_valid = v1_ff;
   assign j1_ctrl  = ctrl_ff;
   assign j1_n1    = n1_ff;
   assign j1_n2    = n2_ff;
   assign j1_n3    = n3_ff;
   assign j1_s     = s_ff;
   assign j1_h0    = h0_ff;
   assign j1_h1    = h1_ff;
   assign j1_h2    = h2_ff;

endmodule

`default_nettype wire

// File: hw/rtl/ire_predict.sv
// Prediction pipeline: truncating divides by 2, 3 and 4, then residuals.
// Divide by 3 uses a reciprocal multiply. Depends on ire_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ire_predict
   import ire_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   j1_valid,
   input  job_ctrl_type                           j1_ctrl,
   input  logic signed [SAMPLE_WIDTH+1:0]         j1_n1,
   input  logic signed [SAMPLE_WIDTH+1:0]         j1_n2,
   input  logic signed [SAMPLE_WIDTH+1:0]         j1_n3,
   input  logic signed [SAMPLE_WIDTH-1:0]         j1_s,
   input  logic signed [SAMPLE_WIDTH-1:0]         j1_h0,
   input  logic signed [SAMPLE_WIDTH-1:0]         j1_h1,
   input  logic signed [SAMPLE_WIDTH-1:0]         j1_h2,
   output logic                                   j2_valid,
   output logic                                   push_valid,
   output logic [JOB_CTRL_W+4*SAMPLE_WIDTH-1:0]   push_data
);

   localparam int SW  = SAMPLE_WIDTH;
   localparam int NW  = SAMPLE_WIDTH + 2;
   localparam int MW  = SAMPLE_WIDTH + 1;        // |2a+s| < 2^MW
   localparam int S3  = SAMPLE_WIDTH + 2;        // reciprocal scale
   localparam int PRW = MW + S3;
   localparam logic [S3-1:0] RECIP3 = S3'(((64'd1 << S3) + 64'd2) / 64'd3);

   logic signed [NW-1:0] abs0, abs1;
   logic [MW-1:0]        mag0, mag1;
   logic [PRW-1:0]       prod0, prod1;
   logic signed [NW-1:0] qq1, qq2, qq3;

   logic                 v2_ff, v2_in;
   job_ctrl_type         ctrl_ff;
   logic [PRW-1:0]       prod0_ff, prod1_ff;
   logic                 neg0_ff, neg1_ff;
   logic signed [NW-1:0] qq1_ff, qq2_ff, qq3_ff;
   logic signed [SW-1:0] s_ff, h0_ff, h1_ff, h2_ff;

   logic signed [NW-1:0] pm0, pm1;
   logic signed [NW-1:0] pred0, pred1, pred2;
   logic signed [NW-1:0] d0, d1, d2;

   // Stage A: magnitudes and reciprocal products, quarter/half quotients
   assign abs0 = j1_n1[NW-1] ? -j1_n1 : j1_n1;
   assign abs1 = j1_n2[NW-1] ? -j1_n2 : j1_n2;
   assign mag0 = MW'(abs0);
   assign mag1 = MW'(abs1);
   assign prod0 = mag0 * RECIP3;
   assign prod1 = mag1 * RECIP3;

   // Round toward zero: bias negatives before the arithmetic shift
   assign qq1 = (j1_n1 + (j1_n1[NW-1] ? NW'(3) : NW'(0))) >>> 2;
   assign qq2 = (j1_n2 + (j1_n2[NW-1] ? NW'(1) : NW'(0))) >>> 1;
   assign qq3 = (j1_n3 + (j1_n3[NW-1] ? NW'(3) : NW'(0))) >>> 2;

   assign v2_in = j1_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (j1_valid) begin
         ctrl_ff  <= j1_ctrl;
         prod0_ff <= prod0;
         prod1_ff <= prod1;
         neg0_ff  <= j1_n1[NW-1];
         neg1_ff  <= j1_n2[NW-1];
         qq1_ff   <= qq1;
         qq2_ff   <= qq2;
         qq3_ff   <= qq3;
         s_ff     <= j1_s;
         h0_ff    <= j1_h0;
         h1_ff    <= j1_h1;
         h2_ff    <= j1_h2;
      end
   end

   // Stage B: restore sign of thirds, select, subtract held sample
   assign pm0 = $signed({1'b0, prod0_ff[PRW-1:S3]});
   assign pm1 = $signed({1'b0, prod1_ff[PRW-1:S3]});

   always_comb begin
      if (ctrl_ff.is_last) begin
         pred0 = neg0_ff ? -pm0 : pm0;
         pred1 = neg1_ff ? -pm1 : pm1;
      end else begin
         pred0 = qq1_ff;
         pred1 = qq2_ff;
      end
      pred2 = qq3_ff;
   end

   assign d0 = pred0 - NW'(h0_ff);
   assign d1 = pred1 - NW'(h1_ff);
   assign d2 = pred2 - NW'(h2_ff);

   assign j2_valid   = v2_ff;
   assign push_valid = v2_ff;
   assign push_data  = {ctrl_ff, s_ff, d2[SW-1:0], d1[SW-1:0], d0[SW-1:0]};

endmodule

`default_nettype wire

// File: hw/rtl/ire_queue.sv
// Short job queue between the predictor and the output serializer.
// Register based, one write and one head read per cycle. Depends on ire_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ire_queue
   import ire_pkg::*;
#(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] head_data,
   output logic [QCNT_W-1:0] count
);

   logic [DATA_W-1:0] entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   // Upstream credit check keeps pushes away from a full queue
   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push_valid) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

`default_nettype wire

// File: hw/rtl/ire_back.sv
// Back end: expands each queued job into its results, one per cycle unless rsp
// stalls, into the registered result channel. Depends on ire_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ire_back
   import ire_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [QCNT_W-1:0]                      q_count,
   input  logic [JOB_CTRL_W+4*SAMPLE_WIDTH-1:0]   head_data,
   output logic                                   pop,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]                 rsp_tdata,
   output logic [RSP_TUSER_W-1:0]                 rsp_tuser,
   output logic                                   rsp_tlast
);

   localparam int SW = SAMPLE_WIDTH;
   localparam logic [BEAT_W-1:0] FINAL_BEAT_START = 2'd0;  // full value only
   localparam logic [BEAT_W-1:0] FINAL_BEAT_LAST  = 2'd2;  // two residuals
   localparam logic [BEAT_W-1:0] FINAL_BEAT_MID   = 2'd3;  // three residuals

   job_ctrl_type         ctrl;
   logic [SW-1:0]        r0, r1, r2, s;
   logic [SW-1:0]        r_sel;
   logic [BEAT_W-1:0]    beat_ff, beat_in;
   logic [BEAT_W-1:0]    final_beat;
   logic                 is_final;
   logic                 have_job;
   logic                 load;
   logic                 step;

   logic                 valid_ff, valid_in;
   kind_type             kind_ff;
   logic [INDEX_W-1:0]   index_ff;
   logic [VALUE_W-1:0]   value_ff;
   logic                 lrun_ff;
   logic                 lblk_ff;

   assign r0   = head_data[SW-1:0];
   assign r1   = head_data[2*SW-1:SW];
   assign r2   = head_data[3*SW-1:2*SW];
   assign s    = head_data[4*SW-1:3*SW];
   assign ctrl = head_data[4*SW +: JOB_CTRL_W];

   always_comb begin
      priority if (ctrl.only_full) begin
         final_beat = FINAL_BEAT_START;
      end else if (ctrl.is_last) begin
         final_beat = FINAL_BEAT_LAST;
      end else begin
         final_beat = FINAL_BEAT_MID;
      end
   end

   always_comb begin
      unique case (beat_ff)
         2'd0:    r_sel = r0;
         2'd1:    r_sel = r1;
         default: r_sel = r2;
      endcase
   end

   assign is_final = (beat_ff == final_beat);
   assign have_job = (q_count != '0);
   assign load     = !valid_ff || rsp_tready;
   assign step     = load && have_job;
   assign pop      = step && is_final;

   always_comb begin
      beat_in = beat_ff;
      if (step) begin
         beat_in = is_final ? '0 : beat_ff + BEAT_W'(1);
      end
      valid_in = load ? have_job : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         beat_ff  <= beat_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         kind_ff  <= is_final ? KIND_FULL : KIND_RESIDUAL;
         index_ff <= is_final ? ctrl.full_idx : ctrl.res_base + INDEX_W'(beat_ff);
         value_ff <= VALUE_W'(is_final ? s : r_sel);
         lrun_ff  <= is_final;
         lblk_ff  <= is_final && ctrl.is_last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, value_ff, index_ff};
   assign rsp_tuser  = {lblk_ff, kind_ff};
   assign rsp_tlast  = lrun_ff;

endmodule

`default_nettype wire

// File: hw/rtl/interp_residual_encoder.sv
// An anchor's results reach rsp via the front, predictor, queue and back end registers.
// Throughput: one sample transaction per cycle; the back end emits one result per
// cycle, four per group of four samples, so the rate holds with rsp always ready.
// Anchors wait for a free slot in the 4-entry job queue (counting jobs in flight).
// Reset (synchronous, active high): block size 512, position and anchor zero,
// pipeline and queue empty, rsp_tvalid low.
`timescale 1ns / 1ps
`default_nettype none

module interp_residual_encoder
   import ire_pkg::*;
#(
   parameter int MAX_BLOCK_LOG2 = 12,
   parameter int SAMPLE_WIDTH   = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // Block size register: log2 of samples per block
   input  logic                               csr_wen,
   input  logic [CFG_W-1:0]                   csr_wdata,
   // Sample stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]  req_tdata,   // [SW-1:0] sample
   // Result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [RSP_TDATA_W-1:0]             rsp_tdata,   // [11:0] index, [27:12] value
   output logic [RSP_TUSER_W-1:0]             rsp_tuser,   // [0] kind, [1] last_of_block
   output logic                               rsp_tlast    // last_of_run
);

   localparam int SW     = SAMPLE_WIDTH;
   localparam int NW     = SAMPLE_WIDTH + 2;
   localparam int JOB_W  = JOB_CTRL_W + 4 * SAMPLE_WIDTH;
   localparam int OCC_W  = QCNT_W + 1;

   // Front to predictor (stage 1 registers)
   logic                 j1_valid;
   job_ctrl_type         j1_ctrl;
   logic signed [NW-1:0] j1_n1, j1_n2, j1_n3;
   logic signed [SW-1:0] j1_s, j1_h0, j1_h1, j1_h2;

   // Predictor to queue
   logic                 j2_valid;
   logic                 push_valid;
   logic [JOB_W-1:0]     push_data;

   // Queue to back end
   logic [JOB_W-1:0]     head_data;
   logic [QCNT_W-1:0]    q_count;
   logic                 pop;

   // Credit: every job in flight already owns a queue slot
   logic [OCC_W-1:0]     occupancy;
   logic                 credit_ok;

   assign occupancy = OCC_W'(q_count) + OCC_W'(j1_valid) + OCC_W'(j2_valid);
   assign credit_ok = (occupancy < OCC_W'(QUEUE_DEPTH));

   // Front: block position, anchor classification, held samples
   ire_front #(
      .MAX_BLOCK_LOG2 (MAX_BLOCK_LOG2),
      .SAMPLE_WIDTH   (SAMPLE_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .credit_ok  (credit_ok),
      .j1_valid   (j1_valid),
      .j1_ctrl    (j1_ctrl),
      .j1_n1      (j1_n1),
      .j1_n2      (j1_n2),
      .j1_n3      (j1_n3),
      .j1_s       (j1_s),
      .j1_h0      (j1_h0),
      .j1_h1      (j1_h1),
      .j1_h2      (j1_h2)
   );

   // Two-stage predictor: reciprocal multiply, then residual subtract
   ire_predict #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_predict (
      .clock      (clock),
      .reset      (reset),
      .j1_valid   (j1_valid),
      .j1_ctrl    (j1_ctrl),
      .j1_n1      (j1_n1),
      .j1_n2      (j1_n2),
      .j1_n3      (j1_n3),
      .j1_s       (j1_s),
      .j1_h0      (j1_h0),
      .j1_h1      (j1_h1),
      .j1_h2      (j1_h2),
      .j2_valid   (j2_valid),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // Decouples the one-job-per-anchor front from the per-result back end
   ire_queue #(
      .DATA_W (JOB_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .head_data  (head_data),
      .count      (q_count)
   );

   // Back end: residuals in order, then the full value
   ire_back #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_count    (q_count),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// File: hw/rtl/ire_checker.sv
// Port-level checks on the result stream of the encoder, bound to the top.
// Depends on ire_pkg and interp_residual_encoder.
`timescale 1ns / 1ps
`default_nettype none

module ire_checker
   import ire_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [RSP_TUSER_W-1:0] rsp_tuser,
   input logic                   rsp_tlast
);

   // Nothing comes out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Stalled transaction holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Each run closes with its full value, and only the full value closes it
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser[0] == KIND_FULL)))
      else $error("run end does not match full value");

   // End of block is also end of run
   a_block_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("block end without run end");

endmodule

bind interp_residual_encoder ire_checker u_ire_checker (.*);

`default_nettype wire

// File: tb/ire_stream_checker.sv
// Result checker for the interpolation residual encoder: follows the sample and result
// streams, predicts every result and compares it field by field.
// Depends on ire_pkg for widths, the register reset value and the kind encoding.
`timescale 1ns / 1ps

module ire_stream_checker
   import ire_pkg::*;
#(
   parameter int MAX_BLOCK_LOG2 = 12,
   parameter int SAMPLE_WIDTH   = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wen,
   input  logic [CFG_W-1:0]                   csr_wdata,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]  req_tdata,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [RSP_TDATA_W-1:0]             rsp_tdata,
   input  logic [RSP_TUSER_W-1:0]             rsp_tuser,
   input  logic                               rsp_tlast,
   output int                                 fail_count,
   output int                                 pending_count,
   output int                                 checked_count,
   output int                                 block_count
);

   typedef struct packed {
      kind_type           kind;
      logic [INDEX_W-1:0] index;
      logic [VALUE_W-1:0] value;
      logic               run_end;
      logic               block_end;
   } enc_result_type;

   enc_result_type     expected_results[$];
   logic [CFG_W-1:0]   size_log2;
   int                 anchor_val;
   int                 held_val[3];
   logic [INDEX_W-1:0] blk_pos;

   function automatic void queue_result(kind_type kind, int idx, int val,
                                        logic run_end, logic block_end);
      enc_result_type r;
      r.kind      = kind;
      r.index     = idx[INDEX_W-1:0];
      r.value     = val[VALUE_W-1:0];   // residual wraps to the sample width
      r.run_end   = run_end;
      r.block_end = block_end;
      expected_results.push_back(r);
   endfunction

   // One accepted sample: update position, anchor and held samples, queue results.
   // Integer division here truncates toward zero, as the predictions require.
   function automatic void predict_sample(int smp);
      int k;
      int span;
      int slot;
      int grp;
      k = size_log2;
      if (k < MIN_BLOCK_LOG2) k = MIN_BLOCK_LOG2;
      if (k > MAX_BLOCK_LOG2) k = MAX_BLOCK_LOG2;
      span = 1 << k;
      slot = int'(blk_pos) & (span - 1);
      if (slot == span - 1) begin
         // closing anchor of the block: thirds between anchor and this sample
         grp = span / 4 - 1;
         queue_result(KIND_RESIDUAL, 3 * grp, (2 * anchor_val + smp) / 3 - held_val[0],
                      1'b0, 1'b0);
         queue_result(KIND_RESIDUAL, 3 * grp + 1, (anchor_val + 2 * smp) / 3 - held_val[1],
                      1'b0, 1'b0);
         queue_result(KIND_FULL, span / 4, smp, 1'b1, 1'b1);
         anchor_val = smp;
         blk_pos    = '0;
      end else begin
         if (slot % 4 == 0) begin
            if (slot != 0) begin
               grp = slot / 4 - 1;
               queue_result(KIND_RESIDUAL, 3 * grp,
                            (3 * anchor_val + smp) / 4 - held_val[0], 1'b0, 1'b0);
               queue_result(KIND_RESIDUAL, 3 * grp + 1,
                            (anchor_val + smp) / 2 - held_val[1], 1'b0, 1'b0);
               queue_result(KIND_RESIDUAL, 3 * grp + 2,
                            (anchor_val + 3 * smp) / 4 - held_val[2], 1'b0, 1'b0);
            end
            queue_result(KIND_FULL, slot / 4, smp, 1'b1, 1'b0);
            anchor_val = smp;
         end else begin
            held_val[slot % 4 - 1] = smp;
         end
         blk_pos = INDEX_W'((slot + 1) & (span - 1));
      end
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   function automatic void check_result();
      enc_result_type want;
      if (expected_results.size() == 0) begin
         $error("result transaction with nothing expected: tdata %h tuser %b tlast %b",
                rsp_tdata, rsp_tuser, rsp_tlast);
         fail_count++;
         return;
      end
      want = expected_results.pop_front();
      checked_count++;
      if (want.block_end) block_count++;
      compare_field("kind", want.kind, rsp_tuser[0]);
      compare_field("index", want.index, rsp_tdata[INDEX_W-1:0]);
      compare_field("value", want.value, rsp_tdata[INDEX_W +: VALUE_W]);
      compare_field("last_of_run", want.run_end, rsp_tlast);
      compare_field("last_of_block", want.block_end, rsp_tuser[1]);
      compare_field("tdata padding", '0, rsp_tdata[RSP_TDATA_W-1 -: RSP_PAD_W]);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_results.delete();
         size_log2  = CFG_RESET;
         anchor_val = 0;
         held_val   = '{0, 0, 0};
         blk_pos    = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         // a register write restarts the block; held samples are dropped
         if (csr_wen) begin
            size_log2 = csr_wdata;
            blk_pos   = '0;
         end
         if (req_tvalid && req_tready) predict_sample($signed(req_tdata[SAMPLE_WIDTH-1:0]));
      end
      pending_count <= expected_results.size();
   end

endmodule

// File: tb/tb_interp_residual_encoder.sv
// Testbench top for interp_residual_encoder: drives samples, block-size writes and
// result back-pressure; all prediction and checking lives in ire_stream_checker.
// Depends on ire_pkg, interp_residual_encoder and ire_stream_checker.
`timescale 1ns / 1ps

module tb_interp_residual_encoder
   import ire_pkg::*;
;

   localparam int SAMPLE_W        = 16;
   localparam int REQ_W           = ((SAMPLE_W + 7) / 8) * 8;
   localparam int IDLE_PCT        = 34;       // share of idle cycles on either side
   localparam int RSP_HOLD_CYCLES = 64;       // long receiver hold-off, fills the job queue
   localparam int SETTLE_CYCLES   = 8;        // margin past the anchor path through the pipeline
   localparam int RUN_LIMIT_NS    = 2_000_000;

   localparam logic [SAMPLE_W-1:0] SMP_MAX = 16'h7FFF;
   localparam logic [SAMPLE_W-1:0] SMP_MIN = 16'h8000;
   localparam logic [SAMPLE_W-1:0] SMP_NEG1 = 16'hFFFF;

   logic                   clock;
   logic                   reset;
   logic                   csr_wen;
   logic [CFG_W-1:0]       csr_wdata;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata;     // [15:0] sample
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;     // [11:0] index, [27:12] value, [31:28] zero
   logic [RSP_TUSER_W-1:0] rsp_tuser;     // [0] kind, [1] last_of_block
   logic                   rsp_tlast;     // last_of_run

   int fail_count;
   int pending_count;
   int checked_count;
   int block_count;

   // Stimulus-side bookkeeping
   bit                  idle_en;
   int                  hold_requests;
   int                  hold_served;
   int                  samples_sent;
   int                  settings_used;
   logic [SAMPLE_W-1:0] last_sample;

   interp_residual_encoder #(
      .MAX_BLOCK_LOG2 (12),
      .SAMPLE_WIDTH   (SAMPLE_W)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   ire_stream_checker #(
      .MAX_BLOCK_LOG2 (12),
      .SAMPLE_WIDTH   (SAMPLE_W)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_wen       (csr_wen),
      .csr_wdata     (csr_wdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .block_count   (block_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs or never drains its results.
   initial begin
      #(RUN_LIMIT_NS);
      $display("status: fail");
      $finish;
   end

   // Result receiver. Normally idles at random while idle_en is set; each new
   // hold request from the stimulus side drops tready for a long stretch,
   // counted here, while the sender keeps offering transactions.
   initial begin
      rsp_tready  = 1'b0;
      hold_served = 0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_requests) begin
            hold_served++;
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= !idle_en || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // One sample transaction. Idle cycles go in front of it at random; tvalid
   // stays high straight into the next transaction when no gap is drawn.
   task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
      while (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(smp);
      do @(posedge clock); while (!req_tready);
      last_sample = smp;
      samples_sent++;
   endtask

   // Sender pause: stop offering and wait until every expected result is in,
   // then give the block time to finish with trailing held samples.
   task automatic wait_results_done();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Block size write; only called with the block idle.
   task automatic write_block_size(input logic [CFG_W-1:0] log2_sel);
      csr_wen   <= 1'b1;
      csr_wdata <= log2_sel;
      @(posedge clock);
      csr_wen <= 1'b0;
      settings_used++;
   endtask

   // Mostly full-range noise, with extremes and small ramps around the
   // previous sample so predictions land near the sample too.
   function automatic logic [SAMPLE_W-1:0] rand_sample();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         case ($urandom_range(0, 3))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2:       return '0;
            default: return SMP_NEG1;
         endcase
      end else if (pick < 30) begin
         return last_sample + SAMPLE_W'($urandom_range(0, 64)) - SAMPLE_W'(32);
      end
      return SAMPLE_W'($urandom());
   endfunction

   task automatic run_phase(input logic [CFG_W-1:0] log2_sel, input int n_items,
                            input bit with_idle, input bit with_hold);
      wait_results_done();
      idle_en <= with_idle;
      if (with_hold) hold_requests <= hold_requests + 1;
      write_block_size(log2_sel);
      repeat (n_items) send_sample(rand_sample());
   endtask

   initial begin
      reset         = 1'b1;
      csr_wen       = 1'b0;
      csr_wdata     = CFG_RESET;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      idle_en       = 1'b1;
      hold_requests = 0;
      samples_sent  = 0;
      settings_used = 0;
      last_sample   = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, default block of 512. First group: anchors at full scale
      // with held samples at the opposite rail, so residuals wrap.
      send_sample(SMP_MAX);
      send_sample(SMP_MIN); send_sample(SMP_MIN); send_sample(SMP_MIN);
      send_sample(SMP_MAX);
      // rail-to-rail anchors: quarter and half steps that truncate toward zero
      send_sample(SMP_MAX); send_sample(16'h0000); send_sample(16'h0001);
      send_sample(SMP_MIN);
      send_sample(SMP_NEG1); send_sample(16'h0001); send_sample(16'h0000);
      send_sample(SMP_NEG1);
      // two samples left held, then a register write restarts the block
      send_sample(16'h5555); send_sample(16'hAAAA);
      wait_results_done();

      // Register below range acts as the smallest block of four: thirds in the
      // last group, block start with only its full value, last_of_block set.
      write_block_size(4'd0);
      send_sample(SMP_NEG1); send_sample(16'h3039); send_sample(16'hCFC7);
      send_sample(16'h0000);
      send_sample(SMP_MAX); send_sample(SMP_MIN); send_sample(SMP_MAX);
      send_sample(SMP_MIN);

      // Random phases over block sizes; the largest sizes get few transactions.
      run_phase(4'd1, 40, 1'b1, 1'b0);
      run_phase(4'd3, 60, 1'b0, 1'b0);     // long stretch with no idling on either side
      run_phase(4'd4, 40, 1'b0, 1'b1);     // receiver hold-off, sender keeps pushing
      run_phase(4'd15, 12, 1'b1, 1'b0);    // above range acts as the maximum
      run_phase(4'd12, 8, 1'b1, 1'b0);
      run_phase(4'd13, 8, 1'b1, 1'b0);
      run_phase(4'd2, 30, 1'b1, 1'b0);
      run_phase(4'd5, 9, 1'b1, 1'b0);
      wait_results_done();

      $display("summary: %0d sample transactions over %0d block size settings (4 to 4096)",
               samples_sent, settings_used + 1);
      $display("summary: %0d results checked, %0d complete blocks, %0d long receiver stall(s)",
               checked_count, block_count, hold_served);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
